[rtl/core/arc_pkg.sv]
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants for the refraction corrector
// Fixed-point constants of the refraction formula, the CORDIC angle table,
// status codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

    // Field and port widths
    localparam int ALT_W      = 24;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int PD_W       = 14;
    localparam int TC_W       = 15;
    localparam int HUM_W      = 10;
    localparam int WL_W       = 14;

    // Internal datapath widths
    localparam int HM_W  = 40;   // clamped altitude, Q32 degrees
    localparam int DIV_W = 36;   // divisor and partial remainder
    localparam int Q_W   = 34;   // quotient bits per division
    localparam int CX_W  = 34;   // CORDIC x, y and z
    localparam int S30_W = 32;   // atmosphere scale, Q30

    typedef logic signed [CX_W-1:0] t_cx;

    // Q32 degree constants
    localparam logic signed [HM_W-1:0] MIN_ALT32 = -40'sd4294967296;
    localparam logic signed [HM_W-1:0] MAX_ALT32 = 40'sd386115329638;
    localparam logic signed [HM_W-1:0] ZENITH32  = 40'sd386547056640;
    localparam logic signed [HM_W-1:0] C511_32   = 40'sd21947282883;
    localparam logic [63:0]            C103_60   = 64'd11875091497450523853;
    localparam logic [24:0]            DEG2RAD30 = 25'd18740331;
    localparam logic [CX_W-1:0]        CORDIC_X0 = 34'd1073741824;

    // Atmosphere scale terms
    localparam int PD_SCALE = 28866;
    localparam int PD_MAX   = 12000;
    localparam int TC_MIN   = -10000;
    localparam int TC_MAX   = 8000;
    localparam int HUM_MAX  = 1000;
    localparam int WL_MIN   = 10;
    localparam int WL_MAX   = 10000;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OFF     = 2'd0,
        ST_APPLIED = 2'd1,
        ST_UNAVAIL = 2'd2,
        ST_BELOW   = 2'd3
    } t_status;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE     = 3'd4;

    // Truncated atan(2^-i) in Q30 radians
    function automatic t_cx atan_q30(input int idx);
        t_cx v;
        case (idx)
            0:  v = t_cx'(32'h3243F6A8);
            1:  v = t_cx'(32'h1DAC6705);
            2:  v = t_cx'(32'h0FADBAFC);
            3:  v = t_cx'(32'h07F56EA6);
            4:  v = t_cx'(32'h03FEAB76);
            5:  v = t_cx'(32'h01FFD55B);
            6:  v = t_cx'(32'h00FFFAAA);
            7:  v = t_cx'(32'h007FFF55);
            8:  v = t_cx'(32'h003FFFEA);
            9:  v = t_cx'(32'h001FFFFD);
            10: v = t_cx'(32'h000FFFFF);
            11: v = t_cx'(32'h0007FFFF);
            12: v = t_cx'(32'h0003FFFF);
            13: v = t_cx'(32'h0001FFFF);
            14: v = t_cx'(32'h0000FFFF);
            15: v = t_cx'(32'h00007FFF);
            16: v = t_cx'(32'h00003FFF);
            17: v = t_cx'(32'h00001FFF);
            18: v = t_cx'(32'h00000FFF);
            19: v = t_cx'(32'h000007FF);
            20: v = t_cx'(32'h000003FF);
            21: v = t_cx'(32'h000001FF);
            22: v = t_cx'(32'h000000FF);
            23: v = t_cx'(32'h0000007F);
            24: v = t_cx'(32'h0000003F);
            25: v = t_cx'(32'h0000001F);
            26: v = t_cx'(32'h0000000F);
            27: v = t_cx'(32'h00000008);
            28: v = t_cx'(32'h00000004);
            29: v = t_cx'(32'h00000002);
            30: v = t_cx'(32'h00000001);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/atmospheric_refraction_correct.sv]
// ----------------------------------------------------------------------------
// atmospheric_refraction_correct: refraction added to a geometric altitude
// Saemundsson-style refraction in fixed point: a pipelined divider for the
// 10.3/(h+5.11) term, a CORDIC tangent and a second pipelined divider for
// the cotangent ratio, all built as rows of one-bit or one-step cells.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake           | Payload
//  --------+-----+---------------------+--------------------------------------
//  s       | in  | tvalid / tready     | tdata altitude_in, tuser flags
//  m       | out | tvalid / tready     | tdata altitude_out, tuser status
//  cfg     | in  | we                  | idx, wdata
//
//  One word is accepted per cycle unless the output stalls; the depth of the
//  row is set by the two 34-cell divider rows and the 32-cell CORDIC row.
//  All stages advance together whenever the output register is empty or
//  being taken, so a stalled output holds the whole row.
//  The atmosphere scale is recomputed after reset or a configuration
//  write, and settles well before a first word reaches its use.
//  Reset is synchronous and active low; it clears all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module atmospheric_refraction_correct #(
    parameter int ALT_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [arc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [arc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [arc_pkg::ALT_W-1:0]         i_s_tdata,  // [23:0] altitude_in
    input  logic [1:0]                        i_s_tuser,  // [0] has_position, [1] observer_valid
    // Output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [arc_pkg::ALT_W-1:0]         o_m_tdata,  // [23:0] altitude_out
    output logic [arc_pkg::ST_W-1:0]          o_m_tuser   // [1:0] status
);

    import arc_pkg::*;

    localparam int SH    = 32 - ALT_FRAC_BITS;
    localparam int H32_W = ALT_W + SH;
    localparam int H_W   = (H32_W > HM_W) ? H32_W + 1 : HM_W + 1;
    localparam int S_W   = (H_W > DIV_W) ? H_W + 1 : DIV_W + 1;
    localparam int SB1_W = ST_W + ALT_W + HM_W;
    localparam int SB2_W = ST_W + ALT_W;
    localparam int SB3_W = ST_W + ALT_W + 1;
    localparam int NSTEP = 32;
    localparam int ZP_W  = HM_W + 26;
    localparam int MP_W  = S30_W + CX_W;
    localparam logic signed [S_W-1:0] RND = 1 <<< (SH - 1);
    localparam logic signed [S_W-1:0] CAP = 90 * (1 << ALT_FRAC_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                    r_enable;
    logic [PD_W-1:0]         r_pd;
    logic signed [TC_W-1:0]  r_tc;
    logic [HUM_W-1:0]        r_hum;
    logic [WL_W-1:0]         r_wl;
    logic                    r_kick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_pd     <= PD_W'(10100);
            r_tc     <= TC_W'(1000);
            r_hum    <= HUM_W'(500);
            r_wl     <= WL_W'(55);
            r_kick   <= 1'b1;
        end else begin
            r_kick <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:   r_enable <= i_cfg_wdata[0];
                    CFG_PRESSURE: r_pd     <= i_cfg_wdata[PD_W-1:0];
                    CFG_TEMP:     r_tc     <= i_cfg_wdata[TC_W-1:0];
                    CFG_HUMIDITY: r_hum    <= i_cfg_wdata[HUM_W-1:0];
                    CFG_WAVE:     r_wl     <= i_cfg_wdata[WL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Atmosphere scale, recomputed after each write.
    logic [S30_W-1:0] w_s30;
    logic             w_s30_busy;

    arc_s30_div u_s30 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_pd    (r_pd),
        .i_tc    (r_tc),
        .o_s30   (w_s30),
        .o_busy  (w_s30_busy)
    );

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output can move.
    // ------------------------------------------------------------------
    logic w_en;
    logic r_o_valid;

    assign w_en       = !r_o_valid || i_m_tready;
    assign o_s_tready = w_en;

    // ------------------------------------------------------------------
    // Entry stage: status decision, clamp and first divisor
    // ------------------------------------------------------------------
    logic signed [ALT_W-1:0] w_alt;
    logic signed [H_W-1:0]   w_hx;
    logic signed [HM_W-1:0]  w_hm;
    logic signed [HM_W-1:0]  w_d32;
    logic                    w_atm_ok;
    t_status                 w_status;

    assign w_alt = i_s_tdata;
    assign w_hx  = H_W'(signed'({w_alt, {SH{1'b0}}}));

    always_comb begin
        if (w_hx < H_W'(MIN_ALT32)) begin
            w_hm = MIN_ALT32;
        end else if (w_hx > H_W'(MAX_ALT32)) begin
            w_hm = MAX_ALT32;
        end else begin
            w_hm = HM_W'(w_hx);
        end
    end

    assign w_d32 = w_hm + C511_32;

    assign w_atm_ok = (r_pd >= PD_W'(1)) && (r_pd <= PD_W'(PD_MAX)) &&
                      (r_tc >= TC_W'(TC_MIN)) && (r_tc <= TC_W'(TC_MAX)) &&
                      (r_hum <= HUM_W'(HUM_MAX)) &&
                      (r_wl >= WL_W'(WL_MIN)) && (r_wl <= WL_W'(WL_MAX));

    always_comb begin
        if (!r_enable) begin
            w_status = ST_OFF;
        end else if (!i_s_tuser[0] || !i_s_tuser[1] || !w_atm_ok) begin
            w_status = ST_UNAVAIL;
        end else if (w_hx < H_W'(MIN_ALT32)) begin
            w_status = ST_BELOW;
        end else if (w_hx >= H_W'(ZENITH32)) begin
            w_status = ST_UNAVAIL;
        end else begin
            w_status = ST_APPLIED;
        end
    end

    // ------------------------------------------------------------------
    // First divider row: 10.3/(h+5.11) in Q32
    // ------------------------------------------------------------------
    logic             w1_valid [0:Q_W];
    logic [DIV_W-1:0] w1_rem   [0:Q_W];
    logic [Q_W-1:0]   w1_word  [0:Q_W];
    logic [DIV_W-1:0] w1_div   [0:Q_W];
    logic [SB1_W-1:0] w1_sb    [0:Q_W];

    logic             r0_valid;
    logic [DIV_W-1:0] r0_div;
    logic [SB1_W-1:0] r0_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_div <= w_d32[HM_W-1:4];
            r0_sb  <= {w_status, w_alt, w_hm};
        end
    end

    assign w1_valid[0] = r0_valid;
    assign w1_rem[0]   = DIV_W'(C103_60[63:Q_W]);
    assign w1_word[0]  = C103_60[Q_W-1:0];
    assign w1_div[0]   = r0_div;
    assign w1_sb[0]    = r0_sb;

    for (genvar k = 0; k < Q_W; k++) begin : g_div1
        arc_div_cell #(.DW(DIV_W), .QW(Q_W), .SBW(SB1_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w1_valid[k]),
            .i_rem   (w1_rem[k]),
            .i_word  (w1_word[k]),
            .i_div   (w1_div[k]),
            .i_sb    (w1_sb[k]),
            .o_valid (w1_valid[k+1]),
            .o_rem   (w1_rem[k+1]),
            .o_word  (w1_word[k+1]),
            .o_div   (w1_div[k+1]),
            .o_sb    (w1_sb[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Angle stage: argument in degrees to Q30 radians
    // ------------------------------------------------------------------
    logic signed [HM_W-1:0] w_hmz;
    logic signed [HM_W-1:0] w_arg;
    logic signed [ZP_W-1:0] w_zprod;

    logic             rz_valid;
    t_cx              rz_z;
    logic [SB2_W-1:0] rz_sb;

    assign w_hmz   = w1_sb[Q_W][HM_W-1:0];
    assign w_arg   = w_hmz + signed'(HM_W'(w1_word[Q_W]));
    assign w_zprod = w_arg * signed'(26'(DEG2RAD30));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rz_valid <= 1'b0;
        end else if (w_en) begin
            rz_valid <= w1_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rz_z  <= w_zprod[32+CX_W-1:32];
            rz_sb <= w1_sb[Q_W][SB1_W-1:HM_W];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC row: cos and sin of the argument, with common gain
    // ------------------------------------------------------------------
    logic             wc_valid [0:NSTEP];
    t_cx              wc_x     [0:NSTEP];
    t_cx              wc_y     [0:NSTEP];
    t_cx              wc_z     [0:NSTEP];
    logic [SB2_W-1:0] wc_sb    [0:NSTEP];

    assign wc_valid[0] = rz_valid;
    assign wc_x[0]     = CORDIC_X0;
    assign wc_y[0]     = '0;
    assign wc_z[0]     = rz_z;
    assign wc_sb[0]    = rz_sb;

    for (genvar k = 0; k < NSTEP; k++) begin : g_cordic
        arc_cordic_cell #(.STEP(k), .SBW(SB2_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (wc_valid[k]),
            .i_x     (wc_x[k]),
            .i_y     (wc_y[k]),
            .i_z     (wc_z[k]),
            .i_sb    (wc_sb[k]),
            .o_valid (wc_valid[k+1]),
            .o_x     (wc_x[k+1]),
            .o_y     (wc_y[k+1]),
            .o_z     (wc_z[k+1]),
            .o_sb    (wc_sb[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale stage: |S30*x| over 15*y; the sign is carried alongside
    // ------------------------------------------------------------------
    t_cx              w_yp;
    logic [CX_W-1:0]  w_xm;
    logic [MP_W-1:0]  w_prod;
    logic [DIV_W-1:0] w_div2;

    assign w_yp   = (wc_y[NSTEP] <= 0) ? t_cx'(1) : wc_y[NSTEP];
    assign w_xm   = wc_x[NSTEP][CX_W-1] ? CX_W'(-wc_x[NSTEP]) : CX_W'(wc_x[NSTEP]);
    assign w_prod = w_s30 * w_xm;
    assign w_div2 = (DIV_W'(w_yp) << 4) - DIV_W'(w_yp);

    logic             rm_valid;
    logic [DIV_W-1:0] rm_rem;
    logic [Q_W-1:0]   rm_word;
    logic [DIV_W-1:0] rm_div;
    logic [SB3_W-1:0] rm_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_valid <= 1'b0;
        end else if (w_en) begin
            rm_valid <= wc_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_rem  <= DIV_W'(w_prod[MP_W-1:Q_W]);
            rm_word <= w_prod[Q_W-1:0];
            rm_div  <= w_div2;
            rm_sb   <= {wc_sb[NSTEP], wc_x[NSTEP][CX_W-1]};
        end
    end

    // ------------------------------------------------------------------
    // Second divider row: refraction magnitude in Q32 degrees
    // ------------------------------------------------------------------
    logic             w2_valid [0:Q_W];
    logic [DIV_W-1:0] w2_rem   [0:Q_W];
    logic [Q_W-1:0]   w2_word  [0:Q_W];
    logic [DIV_W-1:0] w2_div   [0:Q_W];
    logic [SB3_W-1:0] w2_sb    [0:Q_W];

    assign w2_valid[0] = rm_valid;
    assign w2_rem[0]   = rm_rem;
    assign w2_word[0]  = rm_word;
    assign w2_div[0]   = rm_div;
    assign w2_sb[0]    = rm_sb;

    for (genvar k = 0; k < Q_W; k++) begin : g_div2
        arc_div_cell #(.DW(DIV_W), .QW(Q_W), .SBW(SB3_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w2_valid[k]),
            .i_rem   (w2_rem[k]),
            .i_word  (w2_word[k]),
            .i_div   (w2_div[k]),
            .i_sb    (w2_sb[k]),
            .o_valid (w2_valid[k+1]),
            .o_rem   (w2_rem[k+1]),
            .o_word  (w2_word[k+1]),
            .o_div   (w2_div[k+1]),
            .o_sb    (w2_sb[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: add, round half up, cap at the zenith
    // ------------------------------------------------------------------
    logic                    w_neg;
    logic signed [ALT_W-1:0] w_alt2;
    logic [ST_W-1:0]         w_st2;
    logic signed [S_W-1:0]   w_qx;
    logic signed [S_W-1:0]   w_r32;
    logic signed [S_W-1:0]   w_h2;
    logic signed [S_W-1:0]   w_sum;
    logic signed [S_W-1:0]   w_res;
    logic signed [S_W-1:0]   w_resc;

    assign w_neg  = w2_sb[Q_W][0];
    assign w_alt2 = w2_sb[Q_W][ALT_W:1];
    assign w_st2  = w2_sb[Q_W][SB3_W-1:ALT_W+1];
    assign w_qx   = signed'(S_W'(w2_word[Q_W]));
    assign w_r32  = w_neg ? -w_qx : w_qx;
    assign w_h2   = S_W'(signed'({w_alt2, {SH{1'b0}}}));
    assign w_sum  = w_h2 + w_r32 + RND;
    assign w_res  = w_sum >>> SH;
    assign w_resc = (w_res > CAP) ? CAP : w_res;

    logic [ALT_W-1:0] r_o_alt;
    logic [ST_W-1:0]  r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w2_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_alt    <= (w_st2 == ST_APPLIED) ? w_resc[ALT_W-1:0] : w_alt2;
            r_o_status <= w_st2;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_alt;
    assign o_m_tuser  = r_o_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The atmosphere scale is settled before a corrected word needs it.
    a_s30_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wc_valid[NSTEP] && (wc_sb[NSTEP][SB2_W-1:ALT_W] == ST_APPLIED) |-> !w_s30_busy)
        else $error("atmosphere scale still busy when used");

    // A corrected word always enters the CORDIC row with a non-negative angle.
    a_z_positive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rz_valid && (rz_sb[SB2_W-1:ALT_W] == ST_APPLIED) |-> !rz_z[CX_W-1])
        else $error("negative CORDIC angle for a corrected word");

    // The cotangent divisor is never zero for a corrected word.
    a_div2_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rm_valid && (rm_sb[SB3_W-1:ALT_W+1] == ST_APPLIED) |-> (rm_div != '0))
        else $error("zero divisor in the cotangent divider");

endmodule

`default_nettype wire

[rtl/core/arc_div_cell.sv]
// ----------------------------------------------------------------------------
// arc_div_cell: one restoring division cell
// Develops one quotient bit per cell. The dividend bits leave the top of the
// word register while the quotient bits enter at its bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_div_cell #(
    parameter int DW  = 36,
    parameter int QW  = 34,
    parameter int SBW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_word,
    input  logic [DW-1:0] i_div,
    input  logic [SBW-1:0] i_sb,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_word,
    output logic [DW-1:0] o_div,
    output logic [SBW-1:0] o_sb
);

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_word;
    logic [DW-1:0] r_div;
    logic [SBW-1:0] r_sb;

    logic [DW:0]   n_ext;
    logic [DW:0]   n_diff;

    // Bring down the next dividend bit and try the subtraction.
    assign n_ext  = {i_rem, i_word[QW-1]};
    assign n_diff = n_ext - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // A borrow keeps the remainder from before the subtraction and yields a zero quotient bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_diff[DW] ? n_ext[DW-1:0] : n_diff[DW-1:0];
            r_word <= {i_word[QW-2:0], ~n_diff[DW]};
            r_div  <= i_div;
            r_sb   <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_word  = r_word;
    assign o_div   = r_div;
    assign o_sb    = r_sb;

endmodule

`default_nettype wire

[rtl/core/arc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// arc_cordic_cell: one CORDIC rotation cell
// Rotates the vector by plus or minus atan(2^-STEP) towards a zero residual
// angle, with floor shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_cordic_cell #(
    parameter int STEP = 0,
    parameter int SBW  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  arc_pkg::t_cx  i_x,
    input  arc_pkg::t_cx  i_y,
    input  arc_pkg::t_cx  i_z,
    input  logic [SBW-1:0] i_sb,
    output logic          o_valid,
    output arc_pkg::t_cx  o_x,
    output arc_pkg::t_cx  o_y,
    output arc_pkg::t_cx  o_z,
    output logic [SBW-1:0] o_sb
);

    import arc_pkg::*;

    localparam t_cx ANG = atan_q30(STEP);

    logic  r_valid;
    t_cx   r_x;
    t_cx   r_y;
    t_cx   r_z;
    logic [SBW-1:0] r_sb;

    t_cx   n_x;
    t_cx   n_y;
    t_cx   n_z;

    // Direction follows the sign of the residual angle.
    always_comb begin
        if (!i_z[CX_W-1]) begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - ANG;
        end else begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_sb <= i_sb;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_sb    = r_sb;

endmodule

`default_nettype wire

[rtl/core/arc_s30_div.sv]
// ----------------------------------------------------------------------------
// arc_s30_div: atmosphere scale divider
// Works out P/1010 * 283/(273+T) * 1.02 in Q30 from the pressure and
// temperature registers, one quotient bit per cycle, after reset and after
// every configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_s30_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [arc_pkg::PD_W-1:0]      i_pd,
    input  logic signed [arc_pkg::TC_W-1:0] i_tc,
    output logic [arc_pkg::S30_W-1:0]     o_s30,
    output logic                          o_busy
);

    import arc_pkg::*;

    localparam int NUM_W = 29;
    localparam int DEN_W = 30;
    localparam int CNT_W = 6;

    logic [NUM_W-1:0]  w_num;
    logic signed [31:0] w_den;
    logic [DEN_W-1:0]  w_dv;
    logic [DEN_W:0]    w_ext;
    logic [DEN_W:0]    w_diff;

    logic [DEN_W-1:0]  r_rem;
    logic [S30_W-1:0]  r_word;
    logic [CNT_W-1:0]  r_cnt;

    // Numerator pd*28866 (shifted by 30) and denominator 10100*(27300+tc).
    assign w_num  = NUM_W'(i_pd) * NUM_W'(PD_SCALE);
    assign w_den  = (32'sd27300 + 32'(i_tc)) * 32'sd10100;
    assign w_dv   = w_den[DEN_W-1:0];
    assign w_ext  = {r_rem, r_word[S30_W-1]};
    assign w_diff = w_ext - {1'b0, w_dv};

    // Iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(S30_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The top 27 dividend bits stay below the divisor in the valid range.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DEN_W'(w_num[NUM_W-1:2]);
            r_word <= {w_num[1:0], {(S30_W-2){1'b0}}};
        end else if (r_cnt != '0) begin
            r_rem  <= w_diff[DEN_W] ? w_ext[DEN_W-1:0] : w_diff[DEN_W-1:0];
            r_word <= {r_word[S30_W-2:0], ~w_diff[DEN_W]};
        end
    end

    assign o_s30  = r_word;
    assign o_busy = (r_cnt != '0);

endmodule

`default_nettype wire
